// ----- sv/assert_macros.svh -----
// Assertion helpers; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- sv/ghlts_pkg.sv -----
package ghlts_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int MODE_W         = 3;
	localparam int HOLD_W         = 8;
	localparam int HOLD_US_W      = 18;
	localparam int CFG_DATA_W     = 8;
	localparam int US_PER_MS      = 1000;
	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(10);

	typedef enum logic [MODE_W-1:0] {
		MODE_LATCH  = 3'd1,
		MODE_TOGGLE = 3'd2,
		MODE_EXTEND = 3'd3,
		MODE_LIMIT  = 3'd4
	} mode_t;

	typedef enum logic {
		REG_MODE = 1'b0,
		REG_HOLD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		mode_t                 mode;
		logic [HOLD_US_W-1:0]  hold_us;
	} cfg_t;

endpackage

// ----- sv/ghlts_cfg.sv -----
module ghlts_cfg
	import ghlts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	mode_t                mode_q;
	logic [HOLD_US_W-1:0] hold_us_q;
	logic [MODE_W-1:0]    mode_wr;
	logic [HOLD_W-1:0]    hold_wr;

	assign mode_wr = cfg_data[MODE_W-1:0];
	assign hold_wr = cfg_data[HOLD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LATCH;
			hold_us_q <= HOLD_US_W'(HOLD_RESET * US_PER_MS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: begin
					case (mode_wr) inside
						MODE_LATCH, MODE_TOGGLE, MODE_EXTEND, MODE_LIMIT: begin
							mode_q <= mode_t'(mode_wr);
						end
						default: ;
					endcase
				end
				REG_HOLD: begin
					if (hold_wr != '0)
						hold_us_q <= HOLD_US_W'(hold_wr * US_PER_MS);
				end
				default: ;
			endcase
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.hold_us = hold_us_q;

endmodule

// ----- sv/ghlts_step.sv -----
`include "assert_macros.svh"

module ghlts_step
	import ghlts_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [TIME_WIDTH-1:0] now,
	input  logic                  set_lvl,
	input  logic                  rst_lvl,
	input  cfg_t                  cfg,
	output logic                  held
);

	localparam int CMP_W = (TIME_WIDTH > HOLD_US_W) ? TIME_WIDTH : HOLD_US_W;

	logic [TIME_WIDTH-1:0] start_q;
	logic                  active_q;
	logic                  held_q;
	logic                  prev_set_q;
	logic                  prev_rst_q;

	logic                  set_edge;
	logic                  rst_rise;
	logic [TIME_WIDTH-1:0] start_nx;
	logic                  arm;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  expired;
	logic                  active_nx;
	logic                  held_nx;

	assign set_edge = set_lvl & ~prev_set_q;
	assign rst_rise = rst_lvl & ~prev_rst_q;
	assign start_nx = set_edge ? now : start_q;
	assign arm      = set_edge | active_q;
	assign elapsed  = now - start_nx;
	assign expired  = CMP_W'(elapsed) >= CMP_W'(cfg.hold_us);

	always_comb begin
		active_nx = active_q;
		held_nx   = held_q;
		case (cfg.mode)
			MODE_TOGGLE: begin
				if (set_edge)
					held_nx = ~held_q;
			end
			MODE_EXTEND: begin
				active_nx = arm & ~expired;
				held_nx   = set_lvl | active_nx;
			end
			MODE_LIMIT: begin
				active_nx = arm & set_lvl & ~expired;
				held_nx   = set_lvl & active_nx;
			end
			default: begin
				if (set_edge)
					held_nx = 1'b1;
			end
		endcase
		if (rst_rise) begin
			active_nx = 1'b0;
			held_nx   = 1'b0;
		end
	end

	// window start only moves in the timed modes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			active_q   <= 1'b0;
			held_q     <= 1'b0;
			prev_set_q <= 1'b0;
			prev_rst_q <= 1'b0;
		end else if (en) begin
			if (cfg.mode == MODE_EXTEND || cfg.mode == MODE_LIMIT)
				start_q <= start_nx;
			active_q   <= active_nx;
			held_q     <= held_nx;
			prev_set_q <= set_lvl;
			prev_rst_q <= rst_lvl;
		end
	end

	assign held = held_q;

	`ASSERT_PROP(a_rst_clears, clk, arst_n, en && rst_rise |=> !held_q && !active_q)
	`ASSERT_PROP(a_limit_needs_set, clk, arst_n, en && cfg.mode == MODE_LIMIT && !set_lvl |=> !held_q && !active_q)
	`ASSERT_PROP(a_extend_follows_set, clk, arst_n, en && cfg.mode == MODE_EXTEND && set_lvl && !rst_rise |=> held_q)
	`ASSERT_PROP(a_idle_holds, clk, arst_n, !en |=> $stable(held_q) && $stable(active_q) && $stable(start_q))

endmodule

// ----- sv/gate_hold_latch_toggle_stretch.sv -----
// channel | direction | handshake           | payload
// in      | to block  | in_valid / in_stall  | now_time, trigger, reset_level
// out     | from block| out_valid / out_stall| gate
// cfg     | to block  | cfg_we               | cfg_index, cfg_data
//
// One word per clock while out_stall is low. A word waits in the input register until
// it advances; its gate and out_valid are then registered and held while out_stall is high.
// The update is one TIME_WIDTH-bit subtract and a max(TIME_WIDTH, HOLD_US_W)-bit compare.
// arst_n clears state, mode to latch and hold to 10 ms.
// out_stall holds the result; in_stall rises only when the input register is
// also full.
module gate_hold_latch_toggle_stretch
	import ghlts_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TIME_WIDTH-1:0] now_time,
	input  logic                  trigger,
	input  logic                  reset_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  gate,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                  cfg;
	logic                  valid_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  set_s1;
	logic                  rst_s1;
	logic                  out_valid_q;
	logic                  advance;
	logic                  in_take;

	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1 <= now_time;
			set_s1 <= trigger;
			rst_s1 <= reset_level;
		end
	end

	ghlts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ghlts_step #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.now     (now_s1),
		.set_lvl (set_s1),
		.rst_lvl (rst_s1),
		.cfg     (cfg),
		.held    (gate)
	);

	assign out_valid = out_valid_q;

endmodule
